@@ rtl/assert_macros.svh @@
// Assertion macros for the checker module of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFRM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define DFRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle implication");

// Next-cycle implication that is also checked across reset.
`define DFRM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deframer check failed: reset implication");

`endif

@@ rtl/dfrm_pkg.sv @@
// Package of the deframer: constants, register indexes, types and helpers.
package dfrm_pkg;

    localparam int MAX_MARK_BYTES = 4;
    localparam int MARK_LIMIT     = (MAX_MARK_BYTES < 4) ? MAX_MARK_BYTES : 4;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 3;
    localparam int PAT_W    = 32;
    localparam int COUNT_W  = 8;
    localparam int PAT_BYTES = PAT_W / BYTE_W;
    localparam int BSEL_W   = $clog2(PAT_BYTES);
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [LEN_W-1:0] HEADER_LENGTH_RST  = 3'd2;
    localparam logic [PAT_W-1:0] HEADER_PATTERN_RST = 32'h0000_0000;
    localparam logic [LEN_W-1:0] FOOTER_LENGTH_RST  = 3'd2;
    localparam logic [PAT_W-1:0] FOOTER_PATTERN_RST = 32'h0000_0A0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_LENGTH  = 2'd0,
        CFG_HEADER_PATTERN = 2'd1,
        CFG_FOOTER_LENGTH  = 2'd2,
        CFG_FOOTER_PATTERN = 2'd3
    } t_cfg_idx;

    // Register values as the datapath sees them, lengths already clamped.
    typedef struct packed {
        logic [LEN_W-1:0] header_length;
        logic [PAT_W-1:0] header_pattern;
        logic [LEN_W-1:0] footer_length;
        logic [PAT_W-1:0] footer_pattern;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] body_byte;
        logic              first_of_packet;
        logic              last_of_packet;
    } t_result;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(MARK_LIMIT);
        return (len > lim) ? lim : len;
    endfunction

endpackage

@@ rtl/dfrm_cfg_regs.sv @@
// Configuration register file of the deframer with length clamping.
module dfrm_cfg_regs
    import dfrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAT_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [LEN_W-1:0] r_header_length;
    logic [PAT_W-1:0] r_header_pattern;
    logic [LEN_W-1:0] r_footer_length;
    logic [PAT_W-1:0] r_footer_pattern;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length  <= HEADER_LENGTH_RST;
            r_header_pattern <= HEADER_PATTERN_RST;
            r_footer_length  <= FOOTER_LENGTH_RST;
            r_footer_pattern <= FOOTER_PATTERN_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HEADER_LENGTH:  r_header_length  <= i_cfg_data[LEN_W-1:0];
                CFG_HEADER_PATTERN: r_header_pattern <= i_cfg_data;
                CFG_FOOTER_LENGTH:  r_footer_length  <= i_cfg_data[LEN_W-1:0];
                CFG_FOOTER_PATTERN: r_footer_pattern <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lengths beyond the supported mark size behave as the limit.
    always_comb begin
        o_cfg.header_length  = clamp_len(r_header_length);
        o_cfg.header_pattern = r_header_pattern;
        o_cfg.footer_length  = clamp_len(r_footer_length);
        o_cfg.footer_pattern = r_footer_pattern;
    end

endmodule

@@ rtl/dfrm_step.sv @@
// Packet state of the deframer and the per-byte header and footer logic.
module dfrm_step
    import dfrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [COUNT_W-1:0] r_pkt_count;
    logic [PAT_W-1:0]   r_recent;
    logic [COUNT_W-1:0] n_pkt_count;
    logic [PAT_W-1:0]   n_recent;

    logic               hunting;
    logic [BYTE_W-1:0]  want_byte;
    logic [COUNT_W-1:0] body_count;
    logic [PAT_W-1:0]   shifted;
    logic               footer_hit;
    logic [LEN_W-1:0]   back_full;
    logic [BSEL_W-1:0]  back_sel;
    logic               is_last;

    assign hunting   = r_pkt_count < COUNT_W'(i_cfg.header_length);
    assign want_byte = i_cfg.header_pattern[{r_pkt_count[BSEL_W-1:0], 3'b000} +: BYTE_W];
    assign shifted   = {r_recent[PAT_W-BYTE_W-1:0], i_byte};
    assign body_count = (r_pkt_count == COUNT_MAX) ? r_pkt_count
                                                   : r_pkt_count + COUNT_W'(1);

    // Footer byte k is compared with the byte that lies footer_length-1-k
    // positions back from the newest one.
    always_comb begin
        footer_hit = 1'b1;
        back_full  = '0;
        back_sel   = '0;
        for (int k = 0; k < PAT_BYTES; k++) begin
            if (LEN_W'(k) < i_cfg.footer_length) begin
                back_full = i_cfg.footer_length - LEN_W'(k) - LEN_W'(1);
                back_sel  = back_full[BSEL_W-1:0];
                if (shifted[{back_sel, 3'b000} +: BYTE_W] != i_cfg.footer_pattern[k*BYTE_W +: BYTE_W])
                begin
                    footer_hit = 1'b0;
                end
            end
        end
    end

    assign is_last = (body_count >= COUNT_W'(i_cfg.footer_length)) && footer_hit;

    always_comb begin
        n_pkt_count = r_pkt_count;
        n_recent    = r_recent;
        o_res_valid = 1'b0;
        o_res.body_byte       = i_byte;
        o_res.first_of_packet = (r_pkt_count == COUNT_W'(i_cfg.header_length));
        o_res.last_of_packet  = is_last;
        if (i_go) begin
            if (hunting) begin
                if (i_byte == want_byte) begin
                    n_pkt_count = r_pkt_count + COUNT_W'(1);
                    n_recent    = shifted;
                end else begin
                    n_pkt_count = '0;
                    n_recent    = '0;
                end
            end else begin
                o_res_valid = 1'b1;
                if (is_last) begin
                    n_pkt_count = '0;
                    n_recent    = '0;
                end else begin
                    n_pkt_count = body_count;
                    n_recent    = shifted;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_count <= '0;
            r_recent    <= '0;
        end else begin
            r_pkt_count <= n_pkt_count;
            r_recent    <= n_recent;
        end
    end

endmodule

@@ rtl/header_footer_byte_deframer_unit.sv @@
// Top level of the header/footer byte deframer.
// Path: a body byte accepted into the input register is processed and written into the
// result register once that register is free, and is offered from there.
// Throughput: one byte per cycle while the result channel does not stall.
// Reset: synchronous active-low reset empties both registers, restores the
// configuration defaults and puts the block into header hunting.
module header_footer_byte_deframer_unit
    import dfrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Byte input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_body_byte,
    output logic                 o_first_of_packet,
    output logic                 o_last_of_packet,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAT_W-1:0]     i_cfg_data
);

    t_cfg              cfg;
    t_result           step_res;
    logic              step_valid;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              proc_go;

    // Registers are written whenever a transaction is offered; the user must keep the
    // block idle whenever configuration changes; the block does not enforce it, no hold-off.
    assign o_cfg_ready = 1'b1;

    dfrm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The result register can take a new value when it is empty or when its
    // current transaction completes in this cycle. The byte held in the input
    // register is processed exactly then, whether or not it yields a result,
    // so a header byte also waits while a stalled result holds the register.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_go    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Header hunting, footer compare and packet state update all happen in
    // the cycle the byte leaves the input register.
    dfrm_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (proc_go),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= step_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc_go && step_valid) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_body_byte       = r_out.body_byte;
    assign o_first_of_packet = r_out.first_of_packet;
    assign o_last_of_packet  = r_out.last_of_packet;

endmodule

@@ rtl/dfrm_checker.sv @@
// Port-level assertion checker for the deframer and its bind statement.
`include "assert_macros.svh"
module dfrm_checker
    import dfrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] o_body_byte
);

    // A pending result stays offered while the sink stalls.
    `DFRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A stalled result keeps its byte.
    `DFRM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_body_byte))

    // A fresh result can only come from a byte that was taken through the input register.
    `DFRM_ASSERT_IMPLY(a_out_source, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 2))

    // Reset empties the result register.
    `DFRM_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind header_footer_byte_deframer_unit dfrm_checker u_dfrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_body_byte (o_body_byte)
);

@@ dv/deframer_packet_checker.sv @@
// Checker that predicts the deframer's body bytes and compares them with the result channel.
`timescale 1ns / 100ps

module deframer_packet_checker
    import dfrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [BYTE_W-1:0]    i_body_byte,
    input  logic                 i_first_of_packet,
    input  logic                 i_last_of_packet,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAT_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_bodies_pending
);

    logic [LEN_W-1:0]   cfg_hlen;
    logic [PAT_W-1:0]   cfg_hpat;
    logic [LEN_W-1:0]   cfg_flen;
    logic [PAT_W-1:0]   cfg_fpat;
    logic [COUNT_W-1:0] pkt_count;
    logic [PAT_W-1:0]   tail_bytes;
    t_result            bodies_due[$];
    int                 mismatches = 0;

    function automatic logic [LEN_W-1:0] cap_mark_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(MARK_LIMIT)) ? LEN_W'(MARK_LIMIT) : len;
    endfunction

    // Advances the framing state by one byte; returns 1 when the byte is a body byte.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output t_result res);
        logic [LEN_W-1:0] hl;
        logic [LEN_W-1:0] fl;
        bit               ends;
        int               back;
        hl  = cap_mark_len(cfg_hlen);
        fl  = cap_mark_len(cfg_flen);
        res = '0;
        if (pkt_count < hl) begin
            if (b == cfg_hpat[8*pkt_count +: 8]) begin
                pkt_count++;
                tail_bytes = {tail_bytes[PAT_W-BYTE_W-1:0], b};
            end else begin
                pkt_count  = '0;
                tail_bytes = '0;
            end
            return 1'b0;
        end
        res.first_of_packet = (pkt_count == hl);
        if (pkt_count != COUNT_MAX) begin
            pkt_count++;
        end
        tail_bytes = {tail_bytes[PAT_W-BYTE_W-1:0], b};
        // The footer is only compared once the packet is at least as long as it.
        ends = (pkt_count >= fl);
        for (int k = 0; k < MARK_LIMIT; k++) begin
            if (k < fl) begin
                back = int'(fl) - 1 - k;
                if (tail_bytes[8*back +: 8] != cfg_fpat[8*k +: 8]) begin
                    ends = 1'b0;
                end
            end
        end
        res.body_byte      = b;
        res.last_of_packet = ends;
        if (ends) begin
            pkt_count  = '0;
            tail_bytes = '0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        t_result due;
        if (!i_rst_n) begin
            cfg_hlen   = HEADER_LENGTH_RST;
            cfg_hpat   = HEADER_PATTERN_RST;
            cfg_flen   = FOOTER_LENGTH_RST;
            cfg_fpat   = FOOTER_PATTERN_RST;
            pkt_count  = '0;
            tail_bytes = '0;
            bodies_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen.body_byte       = i_body_byte;
                seen.first_of_packet = i_first_of_packet;
                seen.last_of_packet  = i_last_of_packet;
                if (bodies_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: byte %02h first %0b last %0b",
                                 seen.body_byte, seen.first_of_packet, seen.last_of_packet);
                    end
                    mismatches++;
                end else begin
                    due = bodies_due.pop_front();
                    if (seen.body_byte !== due.body_byte
                            || seen.first_of_packet !== due.first_of_packet
                            || seen.last_of_packet !== due.last_of_packet) begin
                        if (mismatches < 10) begin
                            $display("result mismatch: expected byte %02h first %0b last %0b,",
                                     due.body_byte, due.first_of_packet, due.last_of_packet,
                                     " got byte %02h first %0b last %0b",
                                     seen.body_byte, seen.first_of_packet, seen.last_of_packet);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_HEADER_LENGTH:  cfg_hlen = i_cfg_data[LEN_W-1:0];
                    CFG_HEADER_PATTERN: cfg_hpat = i_cfg_data;
                    CFG_FOOTER_LENGTH:  cfg_flen = i_cfg_data[LEN_W-1:0];
                    CFG_FOOTER_PATTERN: cfg_fpat = i_cfg_data;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (deframe_byte(i_rx_byte, due)) begin
                    bodies_due.insert(bodies_due.size(), due);
                end
            end
        end
        o_fail_count     <= mismatches;
        o_bodies_pending <= bodies_due.size();
    end

endmodule

@@ dv/header_footer_byte_deframer_unit_test.sv @@
// Top of the deframer testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 100ps

module header_footer_byte_deframer_unit_test;
    import dfrm_pkg::*;

    typedef logic [BYTE_W-1:0] t_run [$];

    // After the last body byte, settling waits so that header bytes still in flight
    // see the old registers.
    localparam int SETTLE_CYCLES = 8;
    // Length of the deliberate result-side hold-off used to back up the block.
    localparam int LONG_HOLD     = 300;
    // Cycles without any transaction before the run is declared hung.
    localparam int HANG_LIMIT    = 2000;
    localparam int PHASES        = 6;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [BYTE_W-1:0]    rx_byte   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    t_cfg_idx             cfg_index = CFG_HEADER_LENGTH;
    logic [PAT_W-1:0]     cfg_data  = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [BYTE_W-1:0]    o_body_byte;
    logic                 o_first_of_packet;
    logic                 o_last_of_packet;
    logic                 o_cfg_ready;

    int                   fail_count;
    int                   bodies_pending;

    // Idling control shared by the sender and the result sink.
    bit                   idle_on     = 1'b1;
    int                   hold_asks   = 0;
    int                   hold_served = 0;
    int                   quiet_cycles = 0;

    // Current framing, with lengths already capped, for building packets.
    int                   cur_hl;
    int                   cur_fl;
    logic [PAT_W-1:0]     cur_hpat;
    logic [PAT_W-1:0]     cur_fpat;

    always #1 clk = ~clk;

    header_footer_byte_deframer_unit i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_body_byte       (o_body_byte),
        .o_first_of_packet (o_first_of_packet),
        .o_last_of_packet  (o_last_of_packet),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    deframer_packet_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (o_in_stall),
        .i_rx_byte         (rx_byte),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .i_body_byte       (o_body_byte),
        .i_first_of_packet (o_first_of_packet),
        .i_last_of_packet  (o_last_of_packet),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_bodies_pending  (bodies_pending)
    );

    // All tasks below are entered just after a rising edge and return just after
    // the edge that completed their last transaction. The byte and register tasks leave
    // valid high on return so that back-to-back transactions need no lowering in between.

    // Offers one byte, sometimes after a short idle burst, and holds it until taken.
    task automatic push_rx_byte(input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
    endtask

    task automatic send_run(input t_run run);
        foreach (run[i]) begin
            push_rx_byte(run[i]);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [PAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
    endtask

    // Writes the whole framing setup; only called once the block has settled.
    task automatic load_framing(input logic [LEN_W-1:0] hl, input logic [PAT_W-1:0] hp,
                                input logic [LEN_W-1:0] fl, input logic [PAT_W-1:0] fp);
        write_reg(CFG_HEADER_LENGTH, PAT_W'(hl));
        write_reg(CFG_HEADER_PATTERN, hp);
        write_reg(CFG_FOOTER_LENGTH, PAT_W'(fl));
        write_reg(CFG_FOOTER_PATTERN, fp);
        cfg_valid <= 1'b0;
        cur_hl   = (hl > MARK_LIMIT) ? MARK_LIMIT : int'(hl);
        cur_fl   = (fl > MARK_LIMIT) ? MARK_LIMIT : int'(fl);
        cur_hpat = hp;
        cur_fpat = fp;
    endtask

    // Stops sending and waits until every predicted body byte has come out,
    // then lets any header byte still inside the block finish.
    task automatic settle_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bodies_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly complete packets with random bodies under the current framing,
    // mixed with headers that break off and stray bytes between packets.
    task automatic send_traffic(input int target, input bit long_first);
        int sent;
        int kind;
        int blen;
        int n;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                for (int i = 0; i < cur_hl; i++) begin
                    push_rx_byte(cur_hpat[8*i +: 8]);
                end
                // An occasional long body drives the byte count into saturation.
                if (long_first || $urandom_range(0, 79) == 0) begin
                    blen = $urandom_range(256, 300);
                end else begin
                    blen = $urandom_range(0, 12);
                end
                long_first = 1'b0;
                repeat (blen) push_rx_byte(BYTE_W'($urandom()));
                for (int k = 0; k < cur_fl; k++) begin
                    push_rx_byte(cur_fpat[8*k +: 8]);
                end
                sent += cur_hl + blen + cur_fl;
            end else if (kind == 7) begin
                n = (cur_hl > 0) ? $urandom_range(0, cur_hl - 1) : 0;
                for (int i = 0; i < n; i++) begin
                    push_rx_byte(cur_hpat[8*i +: 8]);
                end
                push_rx_byte(BYTE_W'($urandom()));
                sent += n + 1;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) push_rx_byte(BYTE_W'($urandom()));
                sent += n;
            end
        end
    endtask

    // Result sink: random stall bursts while idling is on, and a long hold-off
    // whenever the stimulus asks for one.
    initial begin : result_sink
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_served != hold_asks) begin
                hold_served++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Hang detection: any transaction on any channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_run             run;
        int               hl_tab [PHASES];
        int               fl_tab [PHASES];
        logic [PAT_W-1:0] hp;
        logic [PAT_W-1:0] fp;

        // Length extremes and out-of-range values, the latter capped by the block.
        hl_tab = '{4, 1, 7, 2, 3, 0};
        fl_tab = '{4, 1, 3, 6, 0, 2};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset framing: header 00 00, footer 0A 0A. A good packet with a
        // 0xFF body byte, a header that breaks off on its second byte, and a
        // packet whose first body byte is 0x00.
        cur_hl = 2;
        run = '{8'h00, 8'h00, 8'hFF, 8'h0A, 8'h0A, 8'h00, 8'h7E,
                8'h00, 8'h00, 8'h00, 8'h0A, 8'h0A};
        send_run(run);
        settle_outputs();

        // Header AB CD: the byte that breaks a header is not retried as a new
        // start, so AB AB CD yields nothing. Then a packet with a four-byte footer.
        load_framing(3'd2, 32'h0000_CDAB, 3'd4, 32'h0403_0201);
        run = '{8'hAB, 8'hAB, 8'hCD, 8'hAB, 8'hCD, 8'h01, 8'h02, 8'h03, 8'h04};
        send_run(run);
        settle_outputs();

        // No header and no footer: every byte is a one-byte packet.
        load_framing(3'd0, 32'h1234_5678, 3'd0, 32'h9ABC_DEF0);
        run = '{8'h00, 8'hFF, 8'h80};
        send_run(run);
        settle_outputs();

        // No header, all-zero footer of four: the footer must not fire before
        // the packet is four bytes long, even though the history is all zero.
        load_framing(3'd0, 32'h0000_0000, 3'd4, 32'h0000_0000);
        run = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_run(run);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle_outputs();
            // The last part of the run goes without idling on either side.
            idle_on = (ph != PHASES - 1);
            hp = (ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? 32'h0000_0000 : $urandom();
            fp = (ph == 0) ? 32'h0000_0000 : (ph == 1) ? 32'hFFFF_FFFF : $urandom();
            load_framing(LEN_W'(hl_tab[ph]), hp, LEN_W'(fl_tab[ph]), fp);
            if (ph == 1) begin
                // Results are held back while bytes keep coming, so the block
                // fills and has to stall its input.
                hold_asks++;
            end
            if (ph == 2) begin
                // The sender stops mid-stream until every result is out; the
                // block may be inside a packet across the pause.
                send_traffic(100, 1'b0);
                settle_outputs();
                send_traffic(100, 1'b0);
            end else begin
                send_traffic(200, ph == 0);
            end
        end
        settle_outputs();

        if (fail_count == 0 && bodies_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
